[rtl/etf_pkg.sv]
// Package for the escape-time fractal pixel engine.
// Q8.24 constants, config register indexes, sequencer states and
// saturation helpers. No dependencies.
`default_nettype none

package etf_pkg;

  localparam int unsigned QW       = 32;
  localparam int unsigned FracBits = 24;
  localparam int unsigned ColW     = 10;
  localparam int unsigned CntW     = 16;
  localparam int unsigned CfgAddrW = 3;

  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW:0]   EscapeLimit = (QW+1)'(16) <<< FracBits;

  localparam logic [1:0] ModeJulia = 2'd1;
  localparam logic [1:0] ModeShip  = 2'd2;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MODE, REG_MAX_ITER, REG_ORG_RE, REG_ORG_IM,
    REG_STP_RE, REG_STP_IM, REG_JC_RE, REG_JC_IM
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAP_X, ST_MAP_Y, ST_MAP_END,
    ST_SQX, ST_SQY, ST_XY, ST_UPD, ST_FIN
  } state_e;

  function automatic logic signed [QW-1:0] sat32(input logic signed [65:0] v);
    logic signed [QW-1:0] r;
    if (v > 66'(QMax)) r = QMax;
    else if (v < 66'(QMin)) r = QMin;
    else r = v[QW-1:0];
    return r;
  endfunction

  // floor shift of a full product, then saturate
  function automatic logic signed [QW-1:0] qfix(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FracBits;
    return sat32(66'(s));
  endfunction

  function automatic logic signed [QW-1:0] qabs(input logic signed [QW-1:0] a);
    logic signed [QW-1:0] r;
    if (a == QMin) r = QMax;
    else if (a < 0) r = -a;
    else r = a;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/escape_time_fractal_pixel.sv]
// Escape-time fractal pixel engine: Mandelbrot, Julia and Burning Ship.
// Uses etf_pkg and one shared etf_mul multiplier under a small sequencer.
//
//   channel | dir | handshake              | beat
//   cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_addr_i, cfg_data_i
//   pixel   | in  | in_valid_i/in_ready_o   | pixel_col_i, pixel_row_i
//   result  | out | out_valid_o/out_ready_i | iteration_count_o, final_re_o, final_im_o
//
// From accept to result, states MAP_X, MAP_Y and MAP_END map the point, each
// iteration uses the one multiplier three times (SQX, SQY, XY) plus an update
// in state UPD, and state FIN loads the output register when it is free.
// Not ready while a pixel is in flight.
// A finished beat waits in the output register; the next pixel is taken
// meanwhile and only its own result stalls on out_ready_i. cfg is always ready.
`default_nettype none

module escape_time_fractal_pixel (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [etf_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  wire logic [etf_pkg::QW-1:0]              cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [etf_pkg::ColW-1:0]            pixel_col_i,
  input  wire logic [etf_pkg::ColW-1:0]            pixel_row_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [etf_pkg::CntW-1:0]                 iteration_count_o,
  output logic signed [etf_pkg::QW-1:0]            final_re_o,
  output logic signed [etf_pkg::QW-1:0]            final_im_o
);
  import etf_pkg::*;

  // config registers
  logic [1:0]           mode_q;
  logic [CntW-1:0]      max_iter_q;
  logic signed [QW-1:0] org_re_q, org_im_q, stp_re_q, stp_im_q, jc_re_q, jc_im_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      max_iter_q <= CntW'(64);
      org_re_q   <= -QW'(41943040);
      org_im_q   <= -QW'(16777216);
      stp_re_q   <= QW'(73728);
      stp_im_q   <= QW'(32768);
      jc_re_q    <= '0;
      jc_im_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_MODE:     mode_q     <= cfg_data_i[1:0];
        REG_MAX_ITER: max_iter_q <= cfg_data_i[CntW-1:0];
        REG_ORG_RE:   org_re_q   <= cfg_data_i;
        REG_ORG_IM:   org_im_q   <= cfg_data_i;
        REG_STP_RE:   stp_re_q   <= cfg_data_i;
        REG_STP_IM:   stp_im_q   <= cfg_data_i;
        REG_JC_RE:    jc_re_q    <= cfg_data_i;
        REG_JC_IM:    jc_im_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // sequencer and datapath
  state_e               state_q, state_d;
  logic [CntW-1:0]      n_q, n_d;
  logic                 out_valid_q, out_valid_d;
  logic [ColW-1:0]      col_q, col_d, row_q, row_d;
  logic signed [QW-1:0] x_q, x_d, y_q, y_d, cre_q, cre_d, cim_q, cim_d;
  logic signed [QW-1:0] x2_q, x2_d, y2_q, y2_d;
  logic [CntW-1:0]      cnt_out_q, cnt_out_d;
  logic signed [QW-1:0] re_out_q, re_out_d, im_out_q, im_out_d;

  logic signed [QW-1:0]   mul_a, mul_b;
  logic signed [2*QW-1:0] prod;
  logic signed [QW-1:0]   prod_fix;
  logic signed [QW-1:0]   map_sum;
  logic signed [QW:0]     mag;
  logic                   ship;

  etf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign ship     = (mode_q == ModeShip);
  assign prod_fix = qfix(prod);
  assign mag      = (QW+1)'(x2_q) + (QW+1)'(y2_q);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    col_d       = col_q;
    row_d       = row_q;
    x_d         = x_q;
    y_d         = y_q;
    cre_d       = cre_q;
    cim_d       = cim_q;
    x2_d        = x2_q;
    y2_d        = y2_q;
    cnt_out_d   = cnt_out_q;
    re_out_d    = re_out_q;
    im_out_d    = im_out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    mul_a       = x_q;
    mul_b       = x_q;
    map_sum     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          col_d   = pixel_col_i;
          row_d   = pixel_row_i;
          state_d = ST_MAP_X;
        end
      end
      ST_MAP_X: begin
        mul_a   = QW'(col_q);
        mul_b   = stp_re_q;
        state_d = ST_MAP_Y;
      end
      ST_MAP_Y: begin
        x_d     = sat32(66'(org_re_q) + 66'(prod));
        mul_a   = QW'(row_q);
        mul_b   = stp_im_q;
        state_d = ST_MAP_END;
      end
      ST_MAP_END: begin
        map_sum = sat32(66'(org_im_q) + 66'(prod));
        y_d     = map_sum;
        n_d     = '0;
        if (mode_q == ModeJulia) begin
          cre_d = jc_re_q;
          cim_d = jc_im_q;
        end else begin
          cre_d = x_q;
          cim_d = map_sum;
        end
        state_d = ST_SQX;
      end
      ST_SQX: begin
        if (n_q == max_iter_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_SQY;
        end
      end
      ST_SQY: begin
        x2_d    = prod_fix;
        mul_a   = y_q;
        mul_b   = y_q;
        state_d = ST_XY;
      end
      ST_XY: begin
        y2_d = prod_fix;
        if (ship) begin
          mul_a = qabs(x_q);
          mul_b = qabs(y_q);
        end else begin
          mul_a = x_q;
          mul_b = y_q;
        end
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (mag >= EscapeLimit) begin
          state_d = ST_FIN;
        end else begin
          x_d     = sat32(66'(x2_q) - 66'(y2_q) + 66'(cre_q));
          y_d     = sat32((66'(prod_fix) <<< 1) + 66'(cim_q));
          n_d     = n_q + 1'b1;
          state_d = ST_SQX;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cnt_out_d   = n_q;
          re_out_d    = x_q;
          im_out_d    = y_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q     <= col_d;
    row_q     <= row_d;
    x_q       <= x_d;
    y_q       <= y_d;
    cre_q     <= cre_d;
    cim_q     <= cim_d;
    x2_q      <= x2_d;
    y2_q      <= y2_d;
    cnt_out_q <= cnt_out_d;
    re_out_q  <= re_out_d;
    im_out_q  <= im_out_d;
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = cnt_out_q;
  assign final_re_o        = re_out_q;
  assign final_im_o        = im_out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("pixel engine ready right after accepting a beat");

  a_update_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> n_q < max_iter_q)
    else $error("iteration update past the maximum");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD && mag < EscapeLimit |=> n_q == $past(n_q) + 1'b1)
    else $error("iteration count did not advance by one");

  a_result_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> iteration_count_o <= max_iter_q)
    else $error("result count exceeds the maximum");

endmodule

`default_nettype wire

[rtl/etf_mul.sv]
// Shared 32x32 signed multiplier with a registered full-width product.
// Uses etf_pkg for the word width.
`default_nettype none

module etf_mul (
  input  wire logic                          clk_i,
  input  wire logic signed [etf_pkg::QW-1:0] a_i,
  input  wire logic signed [etf_pkg::QW-1:0] b_i,
  output logic signed [2*etf_pkg::QW-1:0]    p_o
);
  import etf_pkg::*;

  logic signed [2*QW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for escape_time_fractal_pixel: directed and random pixels
// over many register views, predicted in Q8.24 and checked beat by beat.
// Depends on rtl/etf_pkg.sv and rtl/escape_time_fractal_pixel.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import etf_pkg::*;

  localparam logic [1:0] ModeMandel = 2'd0;
  localparam logic [1:0] ModeSpare  = 2'd3;
  localparam longint     QOne       = longint'(1) << FracBits;
  localparam longint     QHi        = longint'(QMax);
  localparam longint     QLo        = longint'(QMin);
  localparam longint     EscLim     = longint'(EscapeLimit);
  localparam int         QuietLimit = 1500000;
  localparam int         TailCycles = 64;

  typedef enum logic [1:0] {STIM_PIXEL, STIM_CFG, STIM_DRAIN} stim_kind_e;

  typedef struct packed {
    stim_kind_e        kind;
    logic [ColW-1:0]   col;
    logic [ColW-1:0]   row;
    cfg_reg_e          addr;
    logic [QW-1:0]     data;
  } stim_item_t;

  typedef struct packed {
    logic [CntW-1:0]        cnt;
    logic signed [QW-1:0]   re;
    logic signed [QW-1:0]   im;
  } pixel_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_addr = REG_MODE;
  logic [QW-1:0]         cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ColW-1:0]       pix_col = '0;
  logic [ColW-1:0]       pix_row = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CntW-1:0]       iteration_count;
  logic signed [QW-1:0]  final_re;
  logic signed [QW-1:0]  final_im;

  wire pix_fire = in_valid && in_ready;
  wire cfg_fire = cfg_valid && cfg_ready;
  wire out_fire = out_valid && out_ready;

  stim_item_t    stim_q[$];
  pixel_result_t pending_q[$];

  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 79;
  int          in_flight = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  logic        stim_done = 1'b0;
  logic        wd_hit = 1'b0;

  // shadow copy of the register file
  logic [1:0]           sh_mode = ModeMandel;
  logic [CntW-1:0]      sh_iter_lim = 16'd64;
  logic signed [QW-1:0] sh_org_re = -32'sd41943040;
  logic signed [QW-1:0] sh_org_im = -32'sd16777216;
  logic signed [QW-1:0] sh_stp_re = 32'sd73728;
  logic signed [QW-1:0] sh_stp_im = 32'sd32768;
  logic signed [QW-1:0] sh_jc_re = '0;
  logic signed [QW-1:0] sh_jc_im = '0;

  logic       nxt_in, nxt_cfg;
  stim_item_t head;

  escape_time_fractal_pixel i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_addr_i        (cfg_addr),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .pixel_col_i       (pix_col),
    .pixel_row_i       (pix_row),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .iteration_count_o (iteration_count),
    .final_re_o        (final_re),
    .final_im_o        (final_im)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_q(longint v);
    if (v > QHi) return QHi;
    if (v < QLo) return QLo;
    return v;
  endfunction

  function automatic longint qprod(longint a, longint b);
    return clamp_q((a * b) >>> FracBits);
  endfunction

  function automatic longint fold_abs(longint a);
    return (a < 0) ? clamp_q(-a) : a;
  endfunction

  function automatic pixel_result_t escape_run(logic [ColW-1:0] col, logic [ColW-1:0] row);
    longint x, y, cr, ci, x2, y2, xy;
    int unsigned n;
    pixel_result_t r;
    x = clamp_q(longint'(sh_org_re) + longint'(col) * longint'(sh_stp_re));
    y = clamp_q(longint'(sh_org_im) + longint'(row) * longint'(sh_stp_im));
    cr = x;
    ci = y;
    if (sh_mode == ModeJulia) begin
      cr = longint'(sh_jc_re);
      ci = longint'(sh_jc_im);
    end
    n = 0;
    while (n < sh_iter_lim) begin
      x2 = qprod(x, x);
      y2 = qprod(y, y);
      if (x2 + y2 >= EscLim) break;
      if (sh_mode == ModeShip) begin
        x = fold_abs(x);
        y = fold_abs(y);
      end
      xy = qprod(x, y);
      x = clamp_q(x2 - y2 + cr);
      y = clamp_q(2 * xy + ci);
      n++;
    end
    r.cnt = n[CntW-1:0];
    r.re = x[QW-1:0];
    r.im = y[QW-1:0];
    return r;
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  task automatic push_pixel(int unsigned col, int unsigned row);
    stim_item_t it;
    it = '0;
    it.kind = STIM_PIXEL;
    it.col = ColW'(col);
    it.row = ColW'(row);
    stim_q.push_back(it);
  endtask

  task automatic push_drain();
    stim_item_t it;
    it = '0;
    it.kind = STIM_DRAIN;
    stim_q.push_back(it);
  endtask

  task automatic push_cfg(cfg_reg_e addr, logic [QW-1:0] data);
    stim_item_t it;
    it = '0;
    it.kind = STIM_CFG;
    it.addr = addr;
    it.data = data;
    stim_q.push_back(it);
  endtask

  task automatic load_view(logic [1:0] mode, logic [CntW-1:0] iters,
                           logic [QW-1:0] org_re, logic [QW-1:0] org_im,
                           logic [QW-1:0] stp_re, logic [QW-1:0] stp_im,
                           logic [QW-1:0] jc_re, logic [QW-1:0] jc_im);
    push_cfg(REG_MODE, QW'(mode));
    push_cfg(REG_MAX_ITER, QW'(iters));
    push_cfg(REG_ORG_RE, org_re);
    push_cfg(REG_ORG_IM, org_im);
    push_cfg(REG_STP_RE, stp_re);
    push_cfg(REG_STP_IM, stp_im);
    push_cfg(REG_JC_RE, jc_re);
    push_cfg(REG_JC_IM, jc_im);
  endtask

  function automatic longint rand_q(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  task automatic random_view();
    int unsigned pick, zshift;
    longint stp_re, stp_im, ctr_re, ctr_im;
    logic [1:0] mode;
    logic [CntW-1:0] iters;
    pick = $urandom_range(15);
    mode = (pick == 0) ? ModeSpare : 2'($urandom_range(2));
    iters = CntW'($urandom_range(1, 96));
    if (pick == 1) iters = CntW'($urandom_range(1, 4));
    if (pick == 2) iters = CntW'($urandom_range(200, 400));
    if (pick == 15) begin
      load_view(mode, iters, $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom());
    end else begin
      // 3.5 units across 1024 columns, zoomed in by a power of two
      zshift = $urandom_range(0, 8);
      stp_re = (longint'(57344) >>> zshift) + longint'($urandom_range(0, 63));
      stp_im = (longint'(57344) >>> zshift) + longint'($urandom_range(0, 63));
      if ($urandom_range(7) == 0) stp_re = -stp_re;
      if ($urandom_range(7) == 0) stp_im = -stp_im;
      ctr_re = rand_q(QOne) - (QOne * 3) / 4;
      ctr_im = rand_q(QOne);
      load_view(mode, iters, 32'(ctr_re - 512 * stp_re), 32'(ctr_im - 512 * stp_im),
                32'(stp_re), 32'(stp_im), 32'(rand_q(QOne)), 32'(rand_q(QOne)));
    end
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || in_flight != 0) @(negedge clk_i);
  endtask

  // driver: pixel and register beats from stim_q
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      in_flight = 0;
    end else begin
      in_flight = in_flight + int'(pix_fire) - int'(out_fire);
      nxt_in = in_valid && !pix_fire;
      nxt_cfg = cfg_valid && !cfg_fire;
      if (!nxt_in && !nxt_cfg && stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.kind)
          STIM_PIXEL: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              pix_col <= head.col;
              pix_row <= head.row;
              nxt_in = 1'b1;
              stim_q.delete(0);
            end
          end
          STIM_CFG: begin
            if (in_flight == 0) begin
              cfg_addr <= head.addr;
              cfg_data <= head.data;
              nxt_cfg = 1'b1;
              stim_q.delete(0);
            end
          end
          default: begin
            if (in_flight == 0) stim_q.delete(0);
          end
        endcase
      end
      in_valid <= nxt_in;
      cfg_valid <= nxt_cfg;
    end
  end

  // monitor: register shadow, prediction and result check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_addr)
          REG_MODE:     sh_mode = cfg_data[1:0];
          REG_MAX_ITER: sh_iter_lim = cfg_data[CntW-1:0];
          REG_ORG_RE:   sh_org_re = cfg_data;
          REG_ORG_IM:   sh_org_im = cfg_data;
          REG_STP_RE:   sh_stp_re = cfg_data;
          REG_STP_IM:   sh_stp_im = cfg_data;
          REG_JC_RE:    sh_jc_re = cfg_data;
          default:      sh_jc_im = cfg_data;
        endcase
      end
      if (pix_fire) pending_q.push_back(escape_run(pix_col, pix_row));
      if (out_fire) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no pixel pending", $time);
        end else begin
          check_field("iteration_count", longint'(pending_q[0].cnt), longint'(iteration_count));
          check_field("final_re", longint'(pending_q[0].re), longint'(final_re));
          check_field("final_im", longint'(pending_q[0].im), longint'(final_im));
          pending_q.delete(0);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_fire || cfg_fire || out_fire) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) wd_hit <= 1'b1;
    end
  end

  initial begin
    int unsigned seg, view, k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset view: corners, center, alternating bits
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    push_pixel(1023, 0);
    push_pixel(0, 1023);
    push_pixel(512, 512);
    push_pixel(341, 682);
    // zero iteration bound returns the mapped point
    load_view(ModeMandel, 16'd0, -32'sd41943040, -32'sd16777216, 32'sd57344, 32'sd32768,
              '0, '0);
    push_pixel(100, 200);
    push_pixel(1023, 1023);
    // spare mode code behaves as mandelbrot, julia c ignored
    load_view(ModeSpare, 16'd64, -32'sd41943040, -32'sd16777216, 32'sd57344, 32'sd32768,
              32'sd5033165, 32'sd8388608);
    push_pixel(300, 512);
    push_pixel(700, 600);
    // saturated mapping and extreme register values
    load_view(ModeMandel, 16'hFFFF, QMin, QMax, QMax, QMin, QMax, QMin);
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    // fixed point at zero runs to the full bound
    load_view(ModeJulia, 16'hFFFF, '0, '0, '0, '0, '0, '0);
    push_pixel(0, 0);
    load_view(ModeJulia, 16'd16, '0, '0, 32'sd65536, 32'sd65536, QMax, QMin);
    push_pixel(5, 9);
    push_pixel(1023, 1023);
    // burning ship over both signs
    load_view(ModeShip, 16'd80, -32'sd33554432, -32'sd33554432, 32'sd65536, 32'sd65536,
              '0, '0);
    push_pixel(100, 900);
    push_pixel(700, 100);
    push_pixel(512, 512);
    load_view(ModeJulia, 16'd100, -32'sd25165824, -32'sd16777216, 32'sd49152, 32'sd32768,
              -32'sd13421773, 32'sd2617245);
    push_pixel(512, 512);
    push_pixel(200, 700);
    push_pixel(900, 300);

    for (seg = 0; seg < 3; seg++) begin
      wait_drained();
      send_idle_pct = (seg == 0) ? 28 : (seg == 1) ? 79 : 0;
      recv_idle_pct = (seg == 0) ? 79 : (seg == 1) ? 28 : 0;
      for (view = 0; view < 4; view++) begin
        random_view();
        for (k = 0; k < 77; k++) begin
          push_pixel($urandom_range(1023), $urandom_range(1023));
          if ($urandom_range(49) == 0) push_drain();
        end
      end
    end
    wait_drained();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done || wd_hit);
    if (!wd_hit) repeat (TailCycles) @(posedge clk_i);
    if (wd_hit) $display("%0t: watchdog expired, no beat for %0d cycles", $time, QuietLimit);
    if (pending_q.size() != 0) $display("%0t: %0d results never arrived", $time,
                                        pending_q.size());
    if (!wd_hit && mismatches == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
